// ===== hw/rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, item types and the inter-cell bus type of the binary
// Pearson correlation unit.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int TIME_WIDTH   = 31;
    localparam int FRAC_BITS    = 16;
    localparam int CORR_WIDTH   = FRAC_BITS + 2;
    localparam int PROD_WIDTH   = 2 * TIME_WIDTH;
    localparam int WIDE_WIDTH   = 4 * TIME_WIDTH;
    localparam int REM_WIDTH    = WIDE_WIDTH + 2 * FRAC_BITS + 2;
    localparam int ACC_WIDTH    = WIDE_WIDTH + FRAC_BITS + 1;
    localparam int ROOT_WIDTH   = FRAC_BITS + 1;
    localparam int NUM_CELLS    = FRAC_BITS + 1;
    localparam int IDX_WIDTH    = $clog2(NUM_CELLS);
    localparam int FRONT_STAGES = 5;
    localparam int PIPE_STAGES  = FRONT_STAGES + NUM_CELLS + 1;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] total_time;
        logic [TIME_WIDTH-1:0] time_first;
        logic [TIME_WIDTH-1:0] time_second;
        logic [TIME_WIDTH-1:0] time_both;
    } in_item_t;

    typedef struct packed {
        logic signed [CORR_WIDTH-1:0] correlation;
        logic                         degenerate;
        logic                         input_error;
    } out_item_t;

    // Partial state handed from one root cell to the next.
    typedef struct packed {
        logic [REM_WIDTH-1:0]  rem;
        logic [ACC_WIDTH-1:0]  dacc;
        logic [WIDE_WIDTH-1:0] den;
        logic [ROOT_WIDTH-1:0] root;
        logic                  negative;
        logic                  degenerate;
        logic                  input_error;
    } cell_data_t;

endpackage

// ===== hw/rtl/binary_pearson_correlation_unit.sv =====
// ----------------------------------------------------------------------------
// binary_pearson_correlation_unit
// Fixed-point Pearson correlation of two binary events from their time counts.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while the result side does not stall
// and returns one result item per input item, in order. Five front stages
// check the counts and form the numerator square and the denominator from
// 31 by 31 bit products; then a chain of 17 root cells fixes one bit of the
// magnitude each, from the top bit down, and a last stage applies sign,
// clamp and flags. Every stage has its own valid bit, so a stalled result
// only blocks input once all stages are full.
// ----------------------------------------------------------------------------
module binary_pearson_correlation_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bpc_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output bpc_pkg::out_item_t m_item
);
    import bpc_pkg::*;

    // One valid bit and one load enable per pipeline stage.
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] stage_en;
    cell_data_t             cell_bus [NUM_CELLS+1];
    out_item_t              out_reg;
    out_item_t              out_next;
    cell_data_t             last;
    logic [ROOT_WIDTH-1:0]  mag;

    // A stage may load when it is empty or when its content moves on.
    always_comb begin
        stage_en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || m_ready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    assign s_ready = stage_en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < PIPE_STAGES; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    bpc_front u_front (
        .aclk     (aclk),
        .stage_en (stage_en[FRONT_STAGES-1:0]),
        .in_item  (s_item),
        .out_data (cell_bus[0])
    );

    // Cell i decides bit FRAC_BITS-i of the magnitude.
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        bpc_cell u_cell (
            .aclk     (aclk),
            .load     (stage_en[FRONT_STAGES+i]),
            .bit_idx  (IDX_WIDTH'(FRAC_BITS - i)),
            .in_data  (cell_bus[i]),
            .out_data (cell_bus[i+1])
        );
    end

    // Clamp to one, apply the sign, and zero the value for flagged items.
    always_comb begin
        last = cell_bus[NUM_CELLS];
        mag  = (last.root > (ROOT_WIDTH'(1) << FRAC_BITS))
             ? (ROOT_WIDTH'(1) << FRAC_BITS) : last.root;
        out_next.degenerate  = last.degenerate;
        out_next.input_error = last.input_error;
        if (last.degenerate || last.input_error) begin
            out_next.correlation = '0;
        end else if (last.negative) begin
            out_next.correlation = -$signed(CORR_WIDTH'(mag));
        end else begin
            out_next.correlation = $signed(CORR_WIDTH'(mag));
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[PIPE_STAGES-1]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = valid_reg[PIPE_STAGES-1];
    assign m_item  = out_reg;

    // Input is refused only when every stage holds an item.
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&valid_reg))
        else $error("input blocked while pipeline has a bubble");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.degenerate && m_item.input_error))
        else $error("both flags set on one result item");

    a_flagged_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_item.degenerate || m_item.input_error))
            |-> (m_item.correlation == '0))
        else $error("flagged result item has nonzero correlation");

    a_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_item.correlation <= $signed(CORR_WIDTH'(1) << FRAC_BITS))
                  && (m_item.correlation >= -$signed(CORR_WIDTH'(1) << FRAC_BITS))))
        else $error("correlation magnitude above one");

endmodule

// ===== hw/rtl/bpc_front.sv =====
// ----------------------------------------------------------------------------
// bpc_front
// Five-stage front end: consistency checks, numerator and denominator
// products, and the split wide squares that seed the root cells.
// ----------------------------------------------------------------------------
module bpc_front (
    input  logic                                   aclk,
    input  logic [bpc_pkg::FRONT_STAGES-1:0]       stage_en,
    input  bpc_pkg::in_item_t                      in_item,
    output bpc_pkg::cell_data_t                    out_data
);
    import bpc_pkg::*;

    logic [TIME_WIDTH-1:0] t_reg, a_reg, b_reg, ab_reg;
    logic [4:1]            err_reg, deg_reg;
    logic [PROD_WIDTH-1:0] p_reg, q2_reg, c2_reg;
    logic [PROD_WIDTH-1:0] mag_reg, q3_reg, c3_reg;
    logic [3:3]            neg3_reg;
    logic                  neg4_reg;
    logic [PROD_WIDTH-1:0] mhh_reg, mhl_reg, mll_reg;
    logic [PROD_WIDTH-1:0] qhch_reg, qhcl_reg, qlch_reg, qlcl_reg;
    cell_data_t            out_reg;

    logic                  err_next, deg_next;
    logic [TIME_WIDTH-1:0] ta_diff, tb_diff;
    logic [WIDE_WIDTH-1:0] msq_sum, den_sum;

    always_comb begin
        err_next = (in_item.time_first > in_item.total_time)
                || (in_item.time_second > in_item.total_time)
                || (in_item.time_both > in_item.time_first)
                || (in_item.time_both > in_item.time_second);
        deg_next = !err_next
                && ((in_item.time_first == '0)
                 || (in_item.time_first == in_item.total_time)
                 || (in_item.time_second == '0)
                 || (in_item.time_second == in_item.total_time));
        ta_diff = t_reg - a_reg;
        tb_diff = t_reg - b_reg;
        msq_sum = (WIDE_WIDTH'(mhh_reg) << PROD_WIDTH)
                + (WIDE_WIDTH'(mhl_reg) << (TIME_WIDTH + 1))
                + WIDE_WIDTH'(mll_reg);
        den_sum = (WIDE_WIDTH'(qhch_reg) << PROD_WIDTH)
                + (WIDE_WIDTH'(qhcl_reg) << TIME_WIDTH)
                + (WIDE_WIDTH'(qlch_reg) << TIME_WIDTH)
                + WIDE_WIDTH'(qlcl_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            t_reg      <= in_item.total_time;
            a_reg      <= in_item.time_first;
            b_reg      <= in_item.time_second;
            ab_reg     <= in_item.time_both;
            err_reg[1] <= err_next;
            deg_reg[1] <= deg_next;
        end
        if (stage_en[1]) begin
            p_reg      <= t_reg * ab_reg;
            q2_reg     <= a_reg * b_reg;
            c2_reg     <= ta_diff * tb_diff;
            err_reg[2] <= err_reg[1];
            deg_reg[2] <= deg_reg[1];
        end
        if (stage_en[2]) begin
            mag_reg     <= (p_reg >= q2_reg) ? (p_reg - q2_reg) : (q2_reg - p_reg);
            neg3_reg[3] <= p_reg < q2_reg;
            q3_reg      <= q2_reg;
            c3_reg      <= c2_reg;
            err_reg[3]  <= err_reg[2];
            deg_reg[3]  <= deg_reg[2];
        end
        if (stage_en[3]) begin
            mhh_reg    <= mag_reg[PROD_WIDTH-1:TIME_WIDTH] * mag_reg[PROD_WIDTH-1:TIME_WIDTH];
            mhl_reg    <= mag_reg[PROD_WIDTH-1:TIME_WIDTH] * mag_reg[TIME_WIDTH-1:0];
            mll_reg    <= mag_reg[TIME_WIDTH-1:0] * mag_reg[TIME_WIDTH-1:0];
            qhch_reg   <= q3_reg[PROD_WIDTH-1:TIME_WIDTH] * c3_reg[PROD_WIDTH-1:TIME_WIDTH];
            qhcl_reg   <= q3_reg[PROD_WIDTH-1:TIME_WIDTH] * c3_reg[TIME_WIDTH-1:0];
            qlch_reg   <= q3_reg[TIME_WIDTH-1:0] * c3_reg[PROD_WIDTH-1:TIME_WIDTH];
            qlcl_reg   <= q3_reg[TIME_WIDTH-1:0] * c3_reg[TIME_WIDTH-1:0];
            neg4_reg   <= neg3_reg[3];
            err_reg[4] <= err_reg[3];
            deg_reg[4] <= deg_reg[3];
        end
        if (stage_en[4]) begin
            out_reg.rem         <= REM_WIDTH'(msq_sum) << (2 * FRAC_BITS);
            out_reg.dacc        <= '0;
            out_reg.den         <= den_sum;
            out_reg.root        <= '0;
            out_reg.negative    <= neg4_reg;
            out_reg.degenerate  <= deg_reg[4];
            out_reg.input_error <= err_reg[4];
        end
    end

    assign out_data = out_reg;

endmodule

// ===== hw/rtl/bpc_cell.sv =====
// ----------------------------------------------------------------------------
// bpc_cell
// One root cell: decides a single bit of the coefficient magnitude by a
// shift-and-subtract test against the running remainder.
// ----------------------------------------------------------------------------
module bpc_cell (
    input  logic                          aclk,
    input  logic                          load,
    input  logic [bpc_pkg::IDX_WIDTH-1:0] bit_idx,
    input  bpc_pkg::cell_data_t           in_data,
    output bpc_pkg::cell_data_t           out_data
);
    import bpc_pkg::*;

    cell_data_t           data_reg;
    cell_data_t           data_next;
    logic [REM_WIDTH-1:0] trial;

    // Setting bit k adds (2*r*2^k + 2^2k) * den to r*r*den.
    always_comb begin
        trial = (REM_WIDTH'(in_data.dacc) << ({1'b0, bit_idx} + 1'b1))
              + (REM_WIDTH'(in_data.den) << {bit_idx, 1'b0});
        data_next = in_data;
        if (trial <= in_data.rem) begin
            data_next.rem  = in_data.rem - trial;
            data_next.dacc = in_data.dacc + (ACC_WIDTH'(in_data.den) << bit_idx);
            data_next.root = in_data.root | (ROOT_WIDTH'(1) << bit_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign out_data = data_reg;

endmodule

// ===== verif/binary_pearson_correlation_unit_tb.sv =====
// ----------------------------------------------------------------------------
// binary_pearson_correlation_unit_tb
// Self-checking testbench for the binary Pearson correlation unit.
// ----------------------------------------------------------------------------
// A short table of directed items covers count extremes, inconsistent and
// degenerate counts, and perfect positive, negative and zero correlation.
// It is followed by random items, most of them consistent counts of varied
// magnitude and a few raw noise items. Items without a hand-written result
// go through an exact wide-integer model of the correlation, and every
// result item is compared field by field, in order, against its expected
// value. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module binary_pearson_correlation_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    localparam int    NUM_RANDOM = 1550;
    localparam int    IDLE_LIMIT = 4000;
    localparam int    DRAIN_WAIT = 40;
    localparam [TIME_WIDTH-1:0] TMAX = {TIME_WIDTH{1'b1}};
    localparam logic signed [CORR_WIDTH-1:0] ONE = 1 <<< FRAC_BITS;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    always #4 aclk = ~aclk;

    binary_pearson_correlation_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Directed items. Where has_exp is set the expected result is written
    // out by hand; the other rows are checked against the correlation model.
    typedef struct {
        in_item_t  item;
        bit        has_exp;
        out_item_t exp;
    } dir_row_t;

    out_item_t expected_results[$];
    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    int        mismatches = 0;
    int        results_seen = 0;
    int        items_sent = 0;
    int        idle_cycles = 0;
    int        n_err = 0;
    int        n_degen = 0;

    function automatic in_item_t counts(input logic [TIME_WIDTH-1:0] t, a, b, ab);
        in_item_t it;
        it.total_time  = t;
        it.time_first  = a;
        it.time_second = b;
        it.time_both   = ab;
        return it;
    endfunction

    function automatic out_item_t result_of(input logic signed [CORR_WIDTH-1:0] c,
                                            input logic dg, input logic er);
        out_item_t r;
        r.correlation = c;
        r.degenerate  = dg;
        r.input_error = er;
        return r;
    endfunction

    // Exact correlation: the largest r with r*r*den <= num*num*2^(2*FRAC_BITS),
    // found one bit at a time from the top, clamped to one, with the sign of num.
    function automatic out_item_t correlate(input in_item_t it);
        logic [63:0]  t, a, b, ab, pos, neg, mag;
        logic [191:0] lhs, rhs, den, cand_w;
        logic [16:0]  root, cand;
        bit           negative;
        out_item_t    r;
        t  = it.total_time;
        a  = it.time_first;
        b  = it.time_second;
        ab = it.time_both;
        r  = '0;
        if (a > t || b > t || ab > a || ab > b) begin
            r.input_error = 1'b1;
            return r;
        end
        if (a == 0 || a == t || b == 0 || b == t) begin
            r.degenerate = 1'b1;
            return r;
        end
        pos = t * ab;
        neg = a * b;
        negative = pos < neg;
        mag = negative ? neg - pos : pos - neg;
        rhs = 192'(mag);
        rhs = (rhs * rhs) << (2 * FRAC_BITS);
        den = 192'(a * b) * 192'((t - a) * (t - b));
        root = '0;
        for (int bt = FRAC_BITS; bt >= 0; bt--) begin
            cand = root | (17'd1 << bt);
            cand_w = 192'(cand);
            lhs = cand_w * cand_w * den;
            if (lhs <= rhs) root = cand;
        end
        if (root > (17'd1 << FRAC_BITS)) root = 17'd1 << FRAC_BITS;
        r.correlation = negative ? -$signed({1'b0, root}) : $signed({1'b0, root});
        return r;
    endfunction

    // Consistent counts of random magnitude; small totals are favored so the
    // borders between degenerate and normal counts are hit often.
    function automatic in_item_t random_counts();
        logic [TIME_WIDTH-1:0] t, a, b, ab, lo;
        int sh;
        sh = $urandom_range(3) == 0 ? 0 : $urandom_range(TIME_WIDTH - 2);
        t = TIME_WIDTH'(($urandom() & TMAX) >> sh);
        if (t < 2) t = TIME_WIDTH'(2 + $urandom_range(3));
        a = TIME_WIDTH'($urandom_range(t - 1, 1));
        b = TIME_WIDTH'($urandom_range(t - 1, 1));
        lo = (a > t - b) ? a - (t - b) : '0;
        ab = TIME_WIDTH'($urandom_range((a < b) ? a : b, lo));
        if ($urandom_range(19) == 0) a = $urandom_range(1) ? '0 : t;
        return counts(t, a, b, ab);
    endfunction

    // Offers one item, with a random gap first, and returns once it is taken.
    // Ready is looked at on the falling edge, where nothing is changing.
    task automatic offer_item(input in_item_t it, input bit has_exp, input out_item_t exp);
        bit taken;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        expected_results.push_back(has_exp ? exp : correlate(it));
        if (expected_results[$].input_error) n_err++;
        if (expected_results[$].degenerate) n_degen++;
        items_sent++;
    endtask

    // The receiver stalls at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Result check. Outputs are stable at the falling edge, and a result seen
    // there with ready high is taken at the next rising edge.
    always @(negedge aclk) begin
        out_item_t exp;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result item %p", m_item);
            end else begin
                exp = expected_results.pop_front();
                if (m_item.correlation !== exp.correlation ||
                    m_item.degenerate !== exp.degenerate ||
                    m_item.input_error !== exp.input_error) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result %0d: expected corr=%0d dg=%0b er=%0b,",
                                  " got corr=%0d dg=%0b er=%0b"},
                                 results_seen, exp.correlation, exp.degenerate,
                                 exp.input_error, m_item.correlation,
                                 m_item.degenerate, m_item.input_error);
                end
            end
        end
    end

    // Watchdog: too many cycles in a row with no item moving on either side.
    always @(negedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (!s_valid && expected_results.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
                $display("binary_pearson_correlation_unit_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        dir_row_t  dir_rows[$];
        out_item_t none;
        none = '0;
        dir_rows = '{
            '{counts(0, 0, 0, 0),                1, result_of(0, 1, 0)},
            '{counts(5, 6, 2, 1),                1, result_of(0, 0, 1)},
            '{counts(5, 2, 6, 1),                1, result_of(0, 0, 1)},
            '{counts(5, 2, 3, 3),                1, result_of(0, 0, 1)},
            '{counts(5, 3, 2, 3),                1, result_of(0, 0, 1)},
            '{counts(0, TMAX, TMAX, TMAX),       1, result_of(0, 0, 1)},
            '{counts(TMAX, TMAX, TMAX, TMAX),    1, result_of(0, 1, 0)},
            '{counts(TMAX, 0, 7, 0),             1, result_of(0, 1, 0)},
            '{counts(TMAX, 7, 0, 0),             1, result_of(0, 1, 0)},
            '{counts(9, 4, 9, 4),                1, result_of(0, 1, 0)},
            '{counts(2, 1, 1, 1),                1, result_of(ONE, 0, 0)},
            '{counts(2, 1, 1, 0),                1, result_of(-ONE, 0, 0)},
            '{counts(4, 2, 2, 1),                1, result_of(0, 0, 0)},
            '{counts(TMAX, TMAX - 1, TMAX - 1, TMAX - 1), 0, none},
            '{counts(TMAX, 1, 1, 1),             0, none},
            '{counts(TMAX, 1, 1, 0),             0, none},
            '{counts(TMAX, TMAX - 1, TMAX - 1, TMAX - 2), 0, none},
            '{counts(TMAX, TMAX >> 1, TMAX >> 1, 0), 0, none},
            '{counts(TMAX, TMAX >> 1, (TMAX >> 1) + 1, TMAX >> 1), 0, none},
            '{counts(10, 3, 7, 2),               0, none},
            '{counts(100, 50, 30, 30),           0, none},
            '{counts(3, 1, 2, 0),                0, none}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            offer_item(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].exp);

        // Idling phases: none, sender gaps, receiver stalls, both at once.
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct    = (ph == 1) ? 52 : (ph == 3) ? 13 : 0;
            receiver_stall_pct = (ph == 2) ? 52 : (ph == 3) ? 13 : 0;
            for (int n = 0; n < NUM_RANDOM / 4; n++) begin
                if ($urandom_range(9) == 0)
                    offer_item(counts(TIME_WIDTH'($urandom()), TIME_WIDTH'($urandom()),
                                      TIME_WIDTH'($urandom()), TIME_WIDTH'($urandom())),
                               0, none);
                else
                    offer_item(random_counts(), 0, none);
            end
        end
        s_valid <= 1'b0;
        receiver_stall_pct = 0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Covered %0d items (%0d inconsistent, %0d degenerate), %0d results checked,",
                 items_sent, n_err, n_degen, results_seen);
        $display("over phases with no idling, sender gaps, receiver stalls and both.");
        if (mismatches == 0) begin
            $display("binary_pearson_correlation_unit_tb: done, clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("binary_pearson_correlation_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
